// ===== rtl/fip_pkg.sv =====
// Shared types and constants for the Feistel index permuter.
package fip_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    // Register index, taken from paddr[3] (registers sit on 8-byte steps).
    localparam logic REG_TOTAL_COUNT = 1'b0;
    localparam logic REG_PASS_KEY    = 1'b1;

    localparam logic [31:0] GOLDEN_STEP = 32'h9E37_79B9;
    localparam logic [31:0] MIX_MUL_A   = 32'h85EB_CA6B;
    localparam logic [31:0] MIX_MUL_B   = 32'hC2B2_AE35;
    localparam logic [31:0] KEY_OFFSET  = 32'h0000_1234;

    localparam logic [1:0] LAST_ROUND = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       scan_load;
        logic       scan_step;
        logic       load_item;
        logic       reduce;
        logic       split;
        logic       mix_a;
        logic       mix_b;
        logic       round_upd;
        logic       join_x;
        logic       out_load;
        logic       load_rk;
        logic [1:0] rk_round;
    } fip_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_more;
        logic n_small;
        logic x_ge_n;
    } fip_status_t;

    // Round number times the golden step, modulo 2^32.
    function automatic logic [31:0] round_step(input logic [1:0] rnd);
        logic [31:0] step;
        case (rnd)
            2'd0:    step = 32'h0000_0000;
            2'd1:    step = GOLDEN_STEP;
            2'd2:    step = 32'h3C6E_F372;
            2'd3:    step = 32'hDAA6_6D2B;
            default: step = 32'h0000_0000;
        endcase
        return step;
    endfunction

endpackage

// ===== rtl/fip_regs.sv =====
// Configuration register block with an APB-style slave port.
module fip_regs
    import fip_pkg::*;
#(
    parameter int INDEX_BITS = 40
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    output logic [INDEX_BITS:0]     total_count,
    output logic [31:0]             mix_key,
    output logic                    count_wr
);

    logic                wr_en;
    logic                reg_sel;
    logic [INDEX_BITS:0] total_count_reg;
    logic [31:0]         pass_key_reg;
    logic [31:0]         mix_key_reg;

    // Byte offset within a register is ignored; bit 3 picks the register.
    assign reg_sel  = paddr[3];
    assign wr_en    = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign count_wr = wr_en && (reg_sel == REG_TOTAL_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_count_reg <= '0;
            pass_key_reg    <= '0;
            mix_key_reg     <= KEY_OFFSET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_TOTAL_COUNT:
                begin
                    total_count_reg <= pwdata[INDEX_BITS:0];
                end
                REG_PASS_KEY:
                begin
                    pass_key_reg <= pwdata[31:0];
                    mix_key_reg  <= pwdata[31:0] + KEY_OFFSET;
                end
                default:
                begin
                    pass_key_reg <= pass_key_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_TOTAL_COUNT: prdata = APB_DATA_W'(total_count_reg);
            REG_PASS_KEY:    prdata = APB_DATA_W'(pass_key_reg);
            default:         prdata = '0;
        endcase
    end

    assign total_count = total_count_reg;
    assign mix_key     = mix_key_reg;

endmodule

// ===== rtl/fip_datapath.sv =====
// Datapath: domain scan, modulo fold, Feistel rounds and output register.
module fip_datapath
    import fip_pkg::*;
#(
    parameter int INDEX_BITS = 40
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fip_cmd_t              cmd,
    output fip_status_t           status,
    input  logic [INDEX_BITS:0]   total_count,
    input  logic [31:0]           mix_key,
    input  logic [INDEX_BITS-1:0] index_in,
    output logic [INDEX_BITS-1:0] index_out
);

    localparam int DW     = INDEX_BITS + (INDEX_BITS % 2);
    localparam int HW     = DW / 2;
    localparam int CW     = INDEX_BITS + 1;
    localparam int HALF_W = $clog2(HW + 1);

    logic [CW-1:0]         n_reg;
    logic [DW-1:0]         dmask_reg;
    logic [HW-1:0]         hmask_reg;
    logic [HALF_W-1:0]     half_reg;
    logic [DW-1:0]         x_reg;
    logic [HW-1:0]         lo_reg;
    logic [HW-1:0]         hi_reg;
    logic [31:0]           rk_reg;
    logic [31:0]           p1_reg;
    logic [31:0]           p2_reg;
    logic [INDEX_BITS-1:0] index_out_reg;

    logic [CW-1:0] limit;
    logic [CW-1:0] n_clamped;
    logic [CW-1:0] nm1;
    logic [CW-1:0] x_ext;
    logic [31:0]   mix_in;
    logic [31:0]   mix_mid;
    logic [31:0]   mix_out;
    logic [HW-1:0] f_masked;

    assign limit     = CW'(1) << INDEX_BITS;
    assign n_clamped = (total_count > limit) ? limit : total_count;
    assign nm1       = n_reg - CW'(1);
    assign x_ext     = CW'(x_reg);

    assign status.n_small   = ((n_reg >> 1) == '0);
    // Grow the even domain two bits at a time until n - 1 fits inside it.
    assign status.scan_more = !status.n_small && ((nm1 & ~CW'(dmask_reg)) != '0);
    assign status.x_ge_n    = (x_ext >= n_reg);

    assign mix_in   = 32'(hi_reg) ^ rk_reg;
    assign mix_mid  = p1_reg ^ (p1_reg >> 13);
    assign mix_out  = p2_reg ^ (p2_reg >> 16);
    assign f_masked = HW'(mix_out) & hmask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= '0;
            dmask_reg <= '0;
            hmask_reg <= '0;
            half_reg  <= '0;
        end
        else if (cmd.scan_load)
        begin
            n_reg     <= n_clamped;
            dmask_reg <= '0;
            hmask_reg <= '0;
            half_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            dmask_reg <= (dmask_reg << 2) | DW'(3);
            hmask_reg <= (hmask_reg << 1) | HW'(1);
            half_reg  <= half_reg + HALF_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            x_reg <= DW'(index_in) & dmask_reg;
        end
        else if (cmd.reduce)
        begin
            x_reg <= DW'(x_ext - n_reg);
        end
        else if (cmd.join_x)
        begin
            x_reg <= (DW'(hi_reg) << half_reg) | DW'(lo_reg);
        end

        if (cmd.split)
        begin
            lo_reg <= HW'(x_reg) & hmask_reg;
            hi_reg <= HW'(x_reg >> half_reg) & hmask_reg;
        end
        else if (cmd.round_upd)
        begin
            hi_reg <= lo_reg ^ f_masked;
            lo_reg <= hi_reg;
        end

        if (cmd.load_rk)
        begin
            rk_reg <= mix_key + round_step(cmd.rk_round);
        end

        if (cmd.mix_a)
        begin
            p1_reg <= 32'(mix_in * MIX_MUL_A);
        end

        if (cmd.mix_b)
        begin
            p2_reg <= 32'(mix_mid * MIX_MUL_B);
        end

        if (cmd.out_load)
        begin
            index_out_reg <= status.n_small ? '0 : x_reg[INDEX_BITS-1:0];
        end
    end

    assign index_out = index_out_reg;

endmodule

// ===== rtl/fip_ctrl.sv =====
// Controller state machine sequencing the scan, fold, rounds and walk.
module fip_ctrl
    import fip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        count_wr,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  fip_status_t status,
    output fip_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SCAN_LOAD = 4'd1;
    localparam logic [3:0] ST_SCAN      = 4'd2;
    localparam logic [3:0] ST_REDUCE    = 4'd3;
    localparam logic [3:0] ST_SPLIT     = 4'd4;
    localparam logic [3:0] ST_MIX_A     = 4'd5;
    localparam logic [3:0] ST_MIX_B     = 4'd6;
    localparam logic [3:0] ST_ROUND     = 4'd7;
    localparam logic [3:0] ST_JOIN      = 4'd8;
    localparam logic [3:0] ST_CHECK     = 4'd9;
    localparam logic [3:0] ST_FINISH    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] rnd_reg;
    logic [1:0] rnd_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE) && !count_wr;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (count_wr)
                begin
                    state_next = ST_SCAN_LOAD;
                end
                else if (accept)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = status.n_small ? ST_FINISH : ST_REDUCE;
                end
            end
            ST_SCAN_LOAD:
            begin
                // A count written at this edge is picked up by loading once more.
                cmd.scan_load = 1'b1;
                state_next    = count_wr ? ST_SCAN_LOAD : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (count_wr)
                begin
                    state_next = ST_SCAN_LOAD;
                end
                else if (status.scan_more)
                begin
                    cmd.scan_step = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REDUCE:
            begin
                // An index at or above n is folded by repeated subtraction.
                if (status.x_ge_n)
                begin
                    cmd.reduce = 1'b1;
                end
                else
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                cmd.split    = 1'b1;
                cmd.load_rk  = 1'b1;
                cmd.rk_round = 2'd0;
                rnd_next     = 2'd0;
                state_next   = ST_MIX_A;
            end
            ST_MIX_A:
            begin
                cmd.mix_a  = 1'b1;
                state_next = ST_MIX_B;
            end
            ST_MIX_B:
            begin
                cmd.mix_b  = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_upd = 1'b1;
                cmd.load_rk   = 1'b1;
                cmd.rk_round  = rnd_reg + 2'd1;
                rnd_next      = rnd_reg + 2'd1;
                state_next    = (rnd_reg == LAST_ROUND) ? ST_JOIN : ST_MIX_A;
            end
            ST_JOIN:
            begin
                cmd.join_x = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // Cycle walking: run another pass until the value lands below n.
                state_next = status.x_ge_n ? ST_SPLIT : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/feistel_index_permuter.sv =====
// Top level of the keyed Feistel index permuter with cycle walking.
//
//   Channel   Signals                                                Direction
//   input     in_valid, in_ready, index_in                           transaction in
//   output    out_valid, out_ready, index_out                        transaction out
//   config    psel, penable, pwrite, paddr, pwdata, prdata, pready   APB slave, 64-bit
//
// With a count above one, a transaction folds the index below n by repeated subtraction,
// then runs walking passes of four rounds (states MIX_A, MIX_B and ROUND, set by the two
// registered multiplies of the round hash) and loads the output register once it is free;
// with a count of at most one it goes straight to the output register. Reset clears both
// registers. A write to total_count starts a domain scan that blocks the input. A new
// input is taken while a result waits in the output register.
module feistel_index_permuter
    import fip_pkg::*;
#(
    parameter int INDEX_BITS = 40
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [INDEX_BITS-1:0] index_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [INDEX_BITS-1:0] index_out
);

    logic [INDEX_BITS:0] total_count;
    logic [31:0]         mix_key;
    logic                count_wr;
    fip_cmd_t            cmd;
    fip_status_t         status;

    fip_regs #(
        .INDEX_BITS (INDEX_BITS)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .total_count (total_count),
        .mix_key     (mix_key),
        .count_wr    (count_wr)
    );

    fip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .count_wr  (count_wr),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    fip_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .total_count (total_count),
        .mix_key     (mix_key),
        .index_in    (index_in),
        .index_out   (index_out)
    );

endmodule
